[hw/rtl/linear_probe_hash_table_defines.svh]
// Assertion macros used by the top-level RTL file of the hash table.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPHT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[hw/rtl/lpht_pkg.sv]
package lpht_pkg;

    localparam int KEY_IN_W   = 16;
    localparam int VALUE_IN_W = 32;
    localparam int SIZE_W     = 7;
    localparam int SLOT_W     = 6;
    localparam int STATUS_W   = 3;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 7'd64;
    localparam logic              ACTION_GET       = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_HIT      = 3'd3,
        ST_MISS     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

endpackage

[hw/rtl/linear_probe_hash_table.sv]
// Channel   Valid        Ready        Payload
// request   i_in_valid   o_in_ready   i_action, i_key, i_value
// result    o_out_valid  i_out_ready  o_status, o_value_out, o_slot
// config    i_cfg_we     (none)       i_cfg_data
//
// After reset every slot of the memory is cleared before the first request is taken.
// A request forms the home slot in the bit-serial remainder unit, then reads each probed slot
// from the registered memory (S_READ) and compares it (S_CHECK), then loads the result in
// S_DONE; the next request is taken once the block is back in S_IDLE.
// One request is in flight at a time; the result register lets a new request enter while
// the previous result waits, and a finished request waits in turn while the result is stalled.
`include "linear_probe_hash_table_defines.svh"

module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int KEY_WIDTH   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_action,
    input  logic [KEY_IN_W-1:0]   i_key,
    input  logic [VALUE_IN_W-1:0] i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [STATUS_W-1:0]   o_status,
    output logic [VALUE_IN_W-1:0] o_value_out,
    output logic [SLOT_W-1:0]     o_slot,
    input  logic                  i_cfg_we,
    input  logic [SIZE_W-1:0]     i_cfg_data
);

    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORD_W = 1 + KEY_WIDTH + VALUE_WIDTH;

    t_state                  r_state, n_state;
    logic [SIZE_W-1:0]       r_table_size;
    logic [SIZE_W-1:0]       size_use;
    logic [AW-1:0]           r_clr, n_clr;
    logic                    r_action, n_action;
    logic [KEY_WIDTH-1:0]    r_key, n_key;
    logic [VALUE_WIDTH-1:0]  r_value, n_value;
    logic [SIZE_W-1:0]       r_size, n_size;
    logic [AW-1:0]           r_idx, n_idx;
    logic [SIZE_W-1:0]       r_probe, n_probe;
    t_status                 r_res_status, n_res_status;
    logic [VALUE_WIDTH-1:0]  r_res_value, n_res_value;
    logic [AW-1:0]           r_res_slot, n_res_slot;
    logic                    r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]     r_status, n_status;
    logic [VALUE_IN_W-1:0]   r_value_out, n_value_out;
    logic [SLOT_W-1:0]       r_slot, n_slot;

    logic [31:0]             key_wide;
    logic [63:0]             value_wide;
    logic [31:0]             idx_wide;
    logic [31:0]             res_slot_wide;
    logic [31:0]             rem_wide;
    logic [63:0]             res_value_wide;
    logic                    accept;
    logic                    rem_start;
    logic                    rem_done;
    logic [SIZE_W-1:0]       rem_out;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [WORD_W-1:0]       ram_wdata;
    logic [WORD_W-1:0]       ram_rdata;
    logic                    rd_occ;
    logic [KEY_WIDTH-1:0]    rd_key;
    logic [VALUE_WIDTH-1:0]  rd_value;

    lpht_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    lpht_rem #(
        .DIVIDEND_W (KEY_WIDTH)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (n_key),
        .i_divisor  (n_size),
        .o_done     (rem_done),
        .o_rem      (rem_out)
    );

    always_comb begin
        size_use = r_table_size;
        if (r_table_size == '0) begin
            size_use = SIZE_W'(1);
        end
        if (32'(r_table_size) > 32'(DEPTH)) begin
            size_use = SIZE_W'(DEPTH);
        end
    end

    assign key_wide       = 32'(i_key);
    assign value_wide     = 64'(i_value);
    assign idx_wide       = 32'(r_idx);
    assign rem_wide       = 32'(rem_out);
    assign res_slot_wide  = 32'(r_res_slot);
    assign res_value_wide = 64'(r_res_value);
    assign rd_occ         = ram_rdata[WORD_W-1];
    assign rd_key         = ram_rdata[VALUE_WIDTH +: KEY_WIDTH];
    assign rd_value       = ram_rdata[VALUE_WIDTH-1:0];
    assign o_in_ready     = (r_state == S_IDLE);
    assign accept         = i_in_valid && o_in_ready;
    assign rem_start      = accept;

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_action     = r_action;
        n_key        = r_key;
        n_value      = r_value;
        n_size       = r_size;
        n_idx        = r_idx;
        n_probe      = r_probe;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_res_slot   = r_res_slot;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_status     = r_status;
        n_value_out  = r_value_out;
        n_slot       = r_slot;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = {1'b1, r_key, r_value};
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (32'(r_clr) == 32'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_action = i_action;
                    n_key    = key_wide[KEY_WIDTH-1:0];
                    n_value  = value_wide[VALUE_WIDTH-1:0];
                    n_size   = size_use;
                    n_probe  = '0;
                    n_state  = S_HASH;
                end
            end
            S_HASH: begin
                if (rem_done) begin
                    n_idx   = rem_wide[AW-1:0];
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_res_value = '0;
                n_res_slot  = '0;
                n_state     = S_DONE;
                if (!rd_occ) begin
                    if (r_action == ACTION_GET) begin
                        n_res_status = ST_MISS;
                    end else begin
                        ram_we       = 1'b1;
                        n_res_status = ST_INSERTED;
                        n_res_slot   = r_idx;
                    end
                end else if (rd_key == r_key) begin
                    n_res_slot = r_idx;
                    if (r_action == ACTION_GET) begin
                        n_res_status = ST_HIT;
                        n_res_value  = rd_value;
                    end else begin
                        ram_we       = 1'b1;
                        n_res_status = ST_UPDATED;
                    end
                end else if (32'(r_probe) + 32'd1 == 32'(r_size)) begin
                    n_res_status = (r_action == ACTION_GET) ? ST_MISS : ST_FULL;
                end else begin
                    n_probe = r_probe + 1'b1;
                    if (idx_wide + 32'd1 == 32'(r_size)) begin
                        n_idx = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_status    = r_res_status;
                    n_value_out = res_value_wide[VALUE_IN_W-1:0];
                    n_slot      = res_slot_wide[SLOT_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_table_size <= TABLE_SIZE_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_table_size <= i_cfg_data;
            end
        end
        r_action     <= n_action;
        r_key        <= n_key;
        r_value      <= n_value;
        r_size       <= n_size;
        r_idx        <= n_idx;
        r_probe      <= n_probe;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_res_slot   <= n_res_slot;
        r_status     <= n_status;
        r_value_out  <= n_value_out;
        r_slot       <= n_slot;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value_out = r_value_out;
    assign o_slot      = r_slot;

    `LPHT_ASSERT_NEXT(a_accept_starts_hash, i_clk, i_rst_n, accept, r_state == S_HASH)
    `LPHT_ASSERT_IMPLIES(a_rem_in_range, i_clk, i_rst_n, rem_done, 32'(rem_out) < 32'(r_size))
    `LPHT_ASSERT_IMPLIES(a_idx_in_range, i_clk, i_rst_n, r_state == S_READ, idx_wide < 32'(r_size))
    `LPHT_ASSERT_IMPLIES(a_probe_bound, i_clk, i_rst_n, r_state == S_CHECK, r_probe < r_size)

endmodule

[hw/rtl/lpht_ram.sv]
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/lpht_rem.sv]
module lpht_rem
    import lpht_pkg::*;
#(
    parameter int DIVIDEND_W = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [SIZE_W-1:0]     i_divisor,
    output logic                  o_done,
    output logic [SIZE_W-1:0]     o_rem
);

    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [DIVIDEND_W-1:0] r_shift, n_shift;
    logic [SIZE_W-1:0]     r_div, n_div;
    logic [SIZE_W-1:0]     r_rem, n_rem;
    logic [SIZE_W:0]       trial;
    logic                  last;

    // One restoring step per cycle: shift in the next dividend bit and
    // subtract the divisor when the partial remainder reaches it.
    always_comb begin
        trial   = {r_rem, r_shift[DIVIDEND_W-1]};
        last    = (r_cnt == CW'(DIVIDEND_W - 1));
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_div   = r_div;
        n_rem   = r_rem;
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_shift = i_dividend;
            n_div   = i_divisor;
            n_rem   = '0;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                trial = trial - {1'b0, r_div};
            end
            n_rem   = trial[SIZE_W-1:0];
            n_shift = r_shift << 1;
            n_cnt   = r_cnt + 1'b1;
            if (last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt   <= n_cnt;
        r_shift <= n_shift;
        r_div   <= n_div;
        r_rem   <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[tb/testbench.sv]
module testbench;
    import lpht_pkg::*;

    localparam logic ACTION_PUT = ~ACTION_GET;
    localparam int   MAX_SLOTS  = 64;
    localparam int   NUM_PHASES = 10;

    typedef struct {
        bit                    is_cfg;
        logic [SIZE_W-1:0]     size;
        logic                  action;
        logic [KEY_IN_W-1:0]   key;
        logic [VALUE_IN_W-1:0] value;
        bit                    no_gap;
    } t_hash_request;

    typedef struct {
        t_status               status;
        logic [VALUE_IN_W-1:0] value_out;
        logic [SLOT_W-1:0]     slot;
    } t_lookup_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_action = 1'b0;
    logic [KEY_IN_W-1:0]   i_key = '0;
    logic [VALUE_IN_W-1:0] i_value = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic [VALUE_IN_W-1:0] o_value_out;
    logic [SLOT_W-1:0]     o_slot;
    logic                  i_cfg_we = 1'b0;
    logic [SIZE_W-1:0]     i_cfg_data = '0;

    t_hash_request  request_queue[$];
    t_lookup_result expected_lookups[$];

    bit                    model_used[MAX_SLOTS];
    logic [KEY_IN_W-1:0]   model_key[MAX_SLOTS];
    logic [VALUE_IN_W-1:0] model_value[MAX_SLOTS];
    int                    model_slots = MAX_SLOTS;

    int request_total = 0;
    int issued = 0;
    int results_seen = 0;
    int fail_count = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    t_hash_request  next_request;
    t_lookup_result oldest;
    bit             accepted;
    logic           valid_next;
    logic           cfg_next;
    logic           ready_next;

    int phase_size[NUM_PHASES]  = '{1, 64, 5, 33, 127, 0, 12, 64, 2, 100};
    int phase_count[NUM_PHASES] = '{30, 250, 60, 120, 60, 20, 80, 120, 30, 30};
    int phase_pool[NUM_PHASES]  = '{4, 80, 10, 45, 30, 3, 20, 70, 5, 40};

    linear_probe_hash_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_slot      (o_slot),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic int slots_in_use(input logic [SIZE_W-1:0] size);
        if (size == 0) begin
            return 1;
        end
        if (size > MAX_SLOTS) begin
            return MAX_SLOTS;
        end
        return int'(size);
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return $urandom_range(0, 2);
        end
        if (r < 92) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 60);
    endfunction

    // Walks the slots from the home slot as the hardware does and updates the table copy.
    function automatic t_lookup_result probe_table(input logic act,
                                                   input logic [KEY_IN_W-1:0] key,
                                                   input logic [VALUE_IN_W-1:0] value);
        t_lookup_result r;
        int             idx;
        bit             stop;
        r.status    = (act == ACTION_GET) ? ST_MISS : ST_FULL;
        r.value_out = '0;
        r.slot      = '0;
        idx  = key % model_slots;
        stop = 1'b0;
        for (int n = 0; n < model_slots && !stop; n++) begin
            if (!model_used[idx]) begin
                if (act != ACTION_GET) begin
                    model_used[idx]  = 1'b1;
                    model_key[idx]   = key;
                    model_value[idx] = value;
                    r.status         = ST_INSERTED;
                    r.slot           = SLOT_W'(idx);
                end
                stop = 1'b1;
            end else if (model_key[idx] == key) begin
                if (act == ACTION_GET) begin
                    r.status    = ST_HIT;
                    r.value_out = model_value[idx];
                end else begin
                    model_value[idx] = value;
                    r.status         = ST_UPDATED;
                end
                r.slot = SLOT_W'(idx);
                stop   = 1'b1;
            end else begin
                idx = (idx + 1 == model_slots) ? 0 : idx + 1;
            end
        end
        return r;
    endfunction

    task automatic add_request(input logic act, input logic [KEY_IN_W-1:0] key,
                               input logic [VALUE_IN_W-1:0] value, input bit no_gap);
        t_hash_request q;
        q.is_cfg = 1'b0;
        q.size   = '0;
        q.action = act;
        q.key    = key;
        q.value  = value;
        q.no_gap = no_gap;
        request_queue.push_back(q);
        request_total++;
    endtask

    task automatic add_size(input logic [SIZE_W-1:0] size);
        t_hash_request q;
        q.is_cfg = 1'b1;
        q.size   = size;
        q.action = ACTION_PUT;
        q.key    = '0;
        q.value  = '0;
        q.no_gap = 1'b0;
        request_queue.push_back(q);
    endtask

    // Most keys are drawn from a pool that crowds the lowest and highest home slots so that probes collide and wrap.
    task automatic add_random_phase(input logic [SIZE_W-1:0] size, input int count,
                                    input int pool_n);
        int pool[$];
        int slots;
        int home;
        int key;
        int pick;
        slots = slots_in_use(size);
        add_size(size);
        for (int i = 0; i < pool_n; i++) begin
            pick = $urandom_range(0, 2);
            if (pick == 0) begin
                home = $urandom_range(0, (slots > 4 ? 4 : slots) - 1);
            end else if (pick == 1) begin
                home = slots - 1 - $urandom_range(0, (slots > 3 ? 3 : slots) - 1);
            end else begin
                home = $urandom_range(0, slots - 1);
            end
            key = home + slots * $urandom_range(0, (65535 - home) / slots);
            pool.push_back(key);
        end
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 15) begin
                add_request(1'($urandom_range(0, 1)), KEY_IN_W'($urandom_range(0, 65535)),
                            $urandom, (i % 50) < 12);
            end else begin
                add_request(($urandom_range(0, 99) < 55) ? ACTION_PUT : ACTION_GET,
                            KEY_IN_W'(pool[$urandom_range(0, pool_n - 1)]), $urandom,
                            (i % 50) < 12);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_cfg_we   <= 1'b0;
            send_gap   <= 0;
            issued     <= 0;
        end else begin
            accepted = i_in_valid && o_in_ready;
            if (accepted) begin
                expected_lookups.push_back(probe_table(i_action, i_key, i_value));
                issued <= issued + 1;
            end
            valid_next = i_in_valid && !accepted;
            cfg_next   = 1'b0;
            if (!valid_next) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                end else if (request_queue.size() != 0) begin
                    if (request_queue[0].is_cfg) begin
                        if (!i_in_valid && !i_cfg_we && o_in_ready
                                && issued == results_seen) begin
                            next_request = request_queue.pop_front();
                            i_cfg_data  <= next_request.size;
                            cfg_next     = 1'b1;
                            model_slots  = slots_in_use(next_request.size);
                        end
                    end else begin
                        next_request = request_queue.pop_front();
                        i_action   <= next_request.action;
                        i_key      <= next_request.key;
                        i_value    <= next_request.value;
                        valid_next  = 1'b1;
                        send_gap   <= next_request.no_gap ? 0 : idle_gap();
                    end
                end
            end
            i_in_valid <= valid_next;
            i_cfg_we   <= cfg_next;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready  <= 1'b0;
            results_seen <= 0;
            stall_left   <= 0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen <= results_seen + 1;
                if (expected_lookups.size() == 0) begin
                    $error("unexpected result: status %0d, value_out %0h, slot %0d",
                           o_status, o_value_out, o_slot);
                    fail_count++;
                end else begin
                    oldest = expected_lookups.pop_front();
                    if (o_status !== oldest.status) begin
                        $error("status: expected %0d, actual %0d", oldest.status, o_status);
                        fail_count++;
                    end
                    if (o_value_out !== oldest.value_out) begin
                        $error("value_out: expected %0h, actual %0h",
                               oldest.value_out, o_value_out);
                        fail_count++;
                    end
                    if (o_slot !== oldest.slot) begin
                        $error("slot: expected %0d, actual %0d", oldest.slot, o_slot);
                        fail_count++;
                    end
                end
            end
            // One long hold-off lets the block fill up and stall its request input.
            if (hold_left != 0) begin
                hold_left  <= hold_left - 1;
                ready_next  = 1'b0;
            end else if (!hold_done && results_seen >= 150) begin
                hold_left  <= 400;
                hold_done  <= 1'b1;
                ready_next  = 1'b0;
            end else if ((results_seen / 64) % 3 == 2) begin
                ready_next = 1'b1;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                ready_next  = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left <= idle_gap();
                ready_next  = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            i_out_ready <= ready_next;
        end
    end

    initial begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
            model_used[i]  = 1'b0;
            model_key[i]   = '0;
            model_value[i] = '0;
        end
        model_slots = slots_in_use(TABLE_SIZE_RESET);

        add_size(7'd64);
        add_request(ACTION_GET, 16'd0, 32'h1234_5678, 1'b0);
        add_request(ACTION_PUT, 16'd0, 32'h0000_0000, 1'b0);
        add_request(ACTION_PUT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        add_request(ACTION_PUT, 16'd64, 32'hA5A5_A5A5, 1'b0);
        add_request(ACTION_GET, 16'd64, 32'h0, 1'b0);
        add_request(ACTION_PUT, 16'd0, 32'h5A5A_5A5A, 1'b1);
        add_request(ACTION_GET, 16'hFFFF, 32'h0, 1'b0);
        add_request(ACTION_PUT, 16'd127, 32'h0F0F_0F0F, 1'b0);
        add_request(ACTION_GET, 16'd191, 32'h0, 1'b0);
        add_size(7'd0);
        add_request(ACTION_GET, 16'd0, 32'h0, 1'b0);
        add_request(ACTION_PUT, 16'd5, 32'hDEAD_BEEF, 1'b0);
        add_request(ACTION_GET, 16'd5, 32'h0, 1'b0);
        add_size(7'd127);
        add_request(ACTION_GET, 16'd127, 32'h0, 1'b0);
        add_size(7'd2);
        add_request(ACTION_PUT, 16'd3, 32'h1111_1111, 1'b0);
        add_request(ACTION_GET, 16'd64, 32'h0, 1'b0);
        add_request(ACTION_GET, 16'hFFFF, 32'h0, 1'b0);
        add_size(7'd64);
        add_request(ACTION_GET, 16'hFFFF, 32'h0, 1'b0);
        add_request(ACTION_GET, 16'd127, 32'h0, 1'b0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            add_random_phase(SIZE_W'(phase_size[p]), phase_count[p], phase_pool[p]);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (issued != request_total || expected_lookups.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (200) @(posedge i_clk);
        if (expected_lookups.size() != 0) begin
            $error("%0d results never arrived", expected_lookups.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("FAIL");
        $finish;
    end

endmodule

[linear_probe_hash_table.f]
+incdir+hw/rtl
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_ram.sv
hw/rtl/lpht_rem.sv
hw/rtl/linear_probe_hash_table.sv
tb/testbench.sv
